// ===== sv/seven_segment_two_wire_display_writer_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_WRITER_DEFINES_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_WRITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSDW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssdw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SSDW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssdw assertion failed");

`endif

// ===== sv/ssdw_pkg.sv =====
`timescale 1ns / 1ps

package ssdw_pkg;

    localparam int unsigned NUM_DIGITS = 4;

    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_DISP = 8'h80;

    localparam logic [2:0] SLOT_DATA_CMD = 3'd0;
    localparam logic [2:0] SLOT_ADDR_CMD = 3'd1;
    localparam logic [2:0] SLOT_FIRST_CODE = 3'd2;
    localparam logic [2:0] SLOT_DISP = 3'd6;
    localparam logic [2:0] SLOT_FINISHED = 3'd7;

    localparam logic [13:0] NUMBER_MAX = 14'd9999;
    localparam logic [2:0] LENGTH_MAX = 3'd4;

    localparam logic CFG_BRIGHTNESS = 1'b0;
    localparam logic CFG_DISPLAY_ON = 1'b1;

    localparam logic [13:0] DIGIT_WEIGHT [NUM_DIGITS] = '{14'd1000, 14'd100, 14'd10, 14'd1};

    typedef enum logic [10:0] {
        PH_START      = 11'b000_0000_0001,
        PH_BIT_LOW    = 11'b000_0000_0010,
        PH_BIT_DATA   = 11'b000_0000_0100,
        PH_BIT_HIGH   = 11'b000_0000_1000,
        PH_ACK_LOW    = 11'b000_0001_0000,
        PH_ACK_HIGH   = 11'b000_0010_0000,
        PH_ACK_SAMPLE = 11'b000_0100_0000,
        PH_ACK_END    = 11'b000_1000_0000,
        PH_STOP_LOW   = 11'b001_0000_0000,
        PH_STOP_CLK   = 11'b010_0000_0000,
        PH_STOP_DIO   = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic clk_release;
        logic dio_release;
        logic busy_res;
        logic ack_missing;
        logic request_dropped;
        logic sequence_done;
    } res_t;

    function automatic logic [6:0] glyph(input logic [3:0] digit);
        logic [6:0] code;
        unique case (digit)
            4'd0: code = 7'b0111111;
            4'd1: code = 7'b0000110;
            4'd2: code = 7'b1011011;
            4'd3: code = 7'b1001111;
            4'd4: code = 7'b1100110;
            4'd5: code = 7'b1101101;
            4'd6: code = 7'b1111101;
            4'd7: code = 7'b0000111;
            4'd8: code = 7'b1111111;
            4'd9: code = 7'b1101111;
            default: code = 7'b0000000;
        endcase
        return code;
    endfunction

    // Byte sent in a given slot; codes holds digit 3 in its top byte.
    function automatic logic [7:0] slot_byte(
        input logic [2:0]  slot,
        input logic [2:0]  len,
        input logic [1:0]  pos,
        input logic        disp_on,
        input logic [2:0]  bright,
        input logic [31:0] codes
    );
        logic [2:0] idx;
        logic [7:0] value;
        idx = 3'(LENGTH_MAX - len + (slot - SLOT_FIRST_CODE));
        if (slot == SLOT_DATA_CMD) begin
            value = CMD_DATA;
        end else if (slot == SLOT_ADDR_CMD) begin
            value = CMD_ADDR | {6'd0, pos};
        end else if (slot < SLOT_DISP) begin
            value = codes[idx[1:0] * 8 +: 8];
        end else begin
            value = CMD_DISP | {4'd0, disp_on, bright};
        end
        return value;
    endfunction

endpackage

// ===== sv/seven_segment_two_wire_display_writer.sv =====
`timescale 1ns / 1ps

// Each accepted transfer's result is registered into the output register, or into the skid stage.
// Throughput: one transfer per cycle; the input stalls only while the output
// register and its skid stage both hold results that are not taken.
// Digit conversion follows an accepted request, one digit per cycle.
// Reset: asynchronous, active low; lines released, idle, brightness 7, display on.
module seven_segment_two_wire_display_writer
    import ssdw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [13:0] number,
    input  logic [7:0]  dots,
    input  logic        zero_fill,
    input  logic [2:0]  shown_length,
    input  logic [1:0]  position,
    input  logic        dio_sense,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        clk_release,
    output logic        dio_release,
    output logic        busy_res,
    output logic        ack_missing,
    output logic        request_dropped,
    output logic        sequence_done
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_slot_reg, byte_slot_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic        clk_line_reg, clk_line_next;
    logic        dio_line_reg, dio_line_next;
    logic        busy_reg, busy_next;
    logic [2:0]  length_reg, length_next;
    logic [1:0]  position_reg, position_next;
    logic [2:0]  brightness_reg;
    logic        display_on_reg;

    logic [7:0]  seg_reg [NUM_DIGITS];
    logic [31:0] seg_flat;

    logic        conv_active_reg, conv_active_next;
    logic [1:0]  conv_cnt_reg, conv_cnt_next;
    logic [13:0] conv_rem_reg, conv_rem_next;
    logic [3:0]  conv_dots_reg, conv_dots_next;
    logic        conv_lz_reg, conv_lz_next;
    logic        conv_leading_reg, conv_leading_next;
    logic [3:0]  conv_digit;
    logic [13:0] conv_rem_out;
    logic [7:0]  conv_code;

    res_t        out_res_reg, skid_res_reg, res_now;
    logic        out_valid_reg, skid_valid_reg;
    logic        in_acc, out_take;
    logic        is_request;
    logic [2:0]  slot_after;
    logic        more_bytes;

    assign in_acc = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign is_request = !kind;
    assign seg_flat = {seg_reg[3], seg_reg[2], seg_reg[1], seg_reg[0]};

    always_comb
    begin
        phase_next = phase_reg;
        byte_slot_next = byte_slot_reg;
        bit_count_next = bit_count_reg;
        shift_next = shift_reg;
        clk_line_next = clk_line_reg;
        dio_line_next = dio_line_reg;
        busy_next = busy_reg;
        length_next = length_reg;
        position_next = position_reg;
        res_now.ack_missing = 1'b0;
        res_now.request_dropped = 1'b0;
        res_now.sequence_done = 1'b0;
        slot_after = byte_slot_reg;
        more_bytes = 1'b0;

        if (is_request) begin
            if (busy_reg) begin
                res_now.request_dropped = 1'b1;
            end else begin
                length_next = (shown_length > LENGTH_MAX) ? LENGTH_MAX : shown_length;
                position_next = position;
                byte_slot_next = SLOT_DATA_CMD;
                bit_count_next = 3'd0;
                phase_next = PH_START;
                shift_next = CMD_DATA;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            unique case (phase_reg)
                PH_START:
                begin
                    dio_line_next = 1'b0;
                    phase_next = PH_BIT_LOW;
                    bit_count_next = 3'd0;
                end
                PH_BIT_LOW:
                begin
                    clk_line_next = 1'b0;
                    phase_next = PH_BIT_DATA;
                end
                PH_BIT_DATA:
                begin
                    dio_line_next = shift_reg[0];
                    phase_next = PH_BIT_HIGH;
                end
                PH_BIT_HIGH:
                begin
                    clk_line_next = 1'b1;
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (bit_count_reg == 3'd7) begin
                        bit_count_next = 3'd0;
                        phase_next = PH_ACK_LOW;
                    end else begin
                        bit_count_next = bit_count_reg + 3'd1;
                        phase_next = PH_BIT_LOW;
                    end
                end
                PH_ACK_LOW:
                begin
                    clk_line_next = 1'b0;
                    dio_line_next = 1'b1;
                    phase_next = PH_ACK_HIGH;
                end
                PH_ACK_HIGH:
                begin
                    clk_line_next = 1'b1;
                    phase_next = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE:
                begin
                    res_now.ack_missing = dio_sense;
                    if (!dio_sense) begin
                        dio_line_next = 1'b0;
                    end
                    phase_next = PH_ACK_END;
                end
                PH_ACK_END:
                begin
                    clk_line_next = 1'b0;
                    if (byte_slot_reg == SLOT_DATA_CMD) begin
                        slot_after = SLOT_ADDR_CMD;
                    end else if (byte_slot_reg == SLOT_ADDR_CMD) begin
                        if (length_reg != 3'd0) begin
                            slot_after = SLOT_FIRST_CODE;
                            more_bytes = 1'b1;
                        end else begin
                            slot_after = SLOT_DISP;
                        end
                    end else if (byte_slot_reg < SLOT_DISP) begin
                        if ((byte_slot_reg - SLOT_FIRST_CODE) + 3'd1 < length_reg) begin
                            slot_after = byte_slot_reg + 3'd1;
                            more_bytes = 1'b1;
                        end else begin
                            slot_after = SLOT_DISP;
                        end
                    end else begin
                        slot_after = SLOT_FINISHED;
                    end
                    byte_slot_next = slot_after;
                    if (more_bytes) begin
                        shift_next = slot_byte(slot_after, length_reg, position_reg,
                                               display_on_reg, brightness_reg, seg_flat);
                        phase_next = PH_BIT_LOW;
                    end else begin
                        phase_next = PH_STOP_LOW;
                    end
                end
                PH_STOP_LOW:
                begin
                    dio_line_next = 1'b0;
                    phase_next = PH_STOP_CLK;
                end
                PH_STOP_CLK:
                begin
                    clk_line_next = 1'b1;
                    phase_next = PH_STOP_DIO;
                end
                PH_STOP_DIO:
                begin
                    dio_line_next = 1'b1;
                    if (byte_slot_reg == SLOT_FINISHED) begin
                        busy_next = 1'b0;
                        res_now.sequence_done = 1'b1;
                        phase_next = PH_START;
                        byte_slot_next = SLOT_DATA_CMD;
                    end else begin
                        shift_next = slot_byte(byte_slot_reg, length_reg, position_reg,
                                               display_on_reg, brightness_reg, seg_flat);
                        phase_next = PH_START;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    phase_next = PH_START;
                    byte_slot_next = SLOT_DATA_CMD;
                    bit_count_next = 3'd0;
                    clk_line_next = 1'b1;
                    dio_line_next = 1'b1;
                end
            endcase
        end

        res_now.clk_release = clk_line_next;
        res_now.dio_release = dio_line_next;
        res_now.busy_res = busy_next;
    end

    // One decimal digit per cycle by restoring compare and subtract.
    always_comb
    begin
        logic [13:0] rem;
        logic [13:0] step;
        logic        show;
        rem = conv_rem_reg;
        conv_digit = 4'd0;
        for (int b = 3; b >= 0; b--) begin
            step = 14'(DIGIT_WEIGHT[conv_cnt_reg] << b);
            if (rem >= step) begin
                rem = rem - step;
                conv_digit[b] = 1'b1;
            end
        end
        conv_rem_out = rem;
        show = (conv_digit != 4'd0) || conv_lz_reg || !conv_leading_reg
               || (conv_cnt_reg == 2'd3);
        conv_code = {conv_dots_reg[~conv_cnt_reg], show ? glyph(conv_digit) : 7'd0};
    end

    always_comb
    begin
        conv_active_next = conv_active_reg;
        conv_cnt_next = conv_cnt_reg;
        conv_rem_next = conv_rem_reg;
        conv_dots_next = conv_dots_reg;
        conv_lz_next = conv_lz_reg;
        conv_leading_next = conv_leading_reg;
        if (in_acc && is_request && !busy_reg) begin
            conv_active_next = 1'b1;
            conv_cnt_next = 2'd0;
            conv_rem_next = (number > NUMBER_MAX) ? NUMBER_MAX : number;
            conv_dots_next = dots[7:4];
            conv_lz_next = zero_fill;
            conv_leading_next = 1'b1;
        end else if (conv_active_reg) begin
            conv_rem_next = conv_rem_out;
            conv_leading_next = conv_leading_reg && (conv_digit == 4'd0);
            conv_cnt_next = conv_cnt_reg + 2'd1;
            if (conv_cnt_reg == 2'd3) begin
                conv_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_active_reg && !(in_acc && is_request && !busy_reg)) begin
            seg_reg[conv_cnt_reg] <= conv_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_START;
            byte_slot_reg <= SLOT_DATA_CMD;
            bit_count_reg <= 3'd0;
            shift_reg <= 8'd0;
            clk_line_reg <= 1'b1;
            dio_line_reg <= 1'b1;
            busy_reg <= 1'b0;
            length_reg <= 3'd0;
            position_reg <= 2'd0;
            conv_active_reg <= 1'b0;
            conv_cnt_reg <= 2'd0;
        end else begin
            if (in_acc) begin
                phase_reg <= phase_next;
                byte_slot_reg <= byte_slot_next;
                bit_count_reg <= bit_count_next;
                shift_reg <= shift_next;
                clk_line_reg <= clk_line_next;
                dio_line_reg <= dio_line_next;
                busy_reg <= busy_next;
                length_reg <= length_next;
                position_reg <= position_next;
            end
            conv_active_reg <= conv_active_next;
            conv_cnt_reg <= conv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        conv_rem_reg <= conv_rem_next;
        conv_dots_reg <= conv_dots_next;
        conv_lz_reg <= conv_lz_next;
        conv_leading_reg <= conv_leading_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            brightness_reg <= 3'd7;
            display_on_reg <= 1'b1;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: brightness_reg <= cfg_data;
                CFG_DISPLAY_ON: display_on_reg <= cfg_data[0];
                default: brightness_reg <= brightness_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg && out_take) begin
                skid_valid_reg <= 1'b0;
            end else if (in_acc) begin
                if (!out_valid_reg || out_take) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (out_take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_take) begin
            out_res_reg <= skid_res_reg;
        end else if (in_acc) begin
            if (!out_valid_reg || out_take) begin
                out_res_reg <= res_now;
            end else begin
                skid_res_reg <= res_now;
            end
        end
    end

    assign clk_release = out_res_reg.clk_release;
    assign dio_release = out_res_reg.dio_release;
    assign busy_res = out_res_reg.busy_res;
    assign ack_missing = out_res_reg.ack_missing;
    assign request_dropped = out_res_reg.request_dropped;
    assign sequence_done = out_res_reg.sequence_done;

endmodule

// ===== sv/ssdw_checker.sv =====
`timescale 1ns / 1ps
`include "seven_segment_two_wire_display_writer_defines.svh"

module ssdw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        clk_release,
    input logic        dio_release,
    input logic        busy_res,
    input logic        ack_missing,
    input logic        request_dropped,
    input logic        sequence_done
);

    // A stalled result transfer keeps its payload.
    `SSDW_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(clk_release) && $stable(dio_release) && $stable(busy_res))

    // The input side only stalls when a result is already waiting.
    `SSDW_ASSERT_SAME(a_stall_has_result, in_stall, out_valid)

    // A finished sequence leaves the writer idle.
    `SSDW_ASSERT_SAME(a_done_idle, out_valid && sequence_done, !busy_res)

    // Dropped requests and acknowledge checks only occur during a sequence.
    `SSDW_ASSERT_SAME(a_flags_busy, out_valid && (request_dropped || ack_missing), busy_res)

endmodule

bind seven_segment_two_wire_display_writer ssdw_checker u_ssdw_checker (.*);

// ===== tb/tb_seven_segment_two_wire_display_writer.sv =====
`timescale 1ns / 1ps

module tb_seven_segment_two_wire_display_writer;
    import ssdw_pkg::*;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_COUNT = 6;
    localparam int RANDOM_ITEMS_PER_PHASE = 80;
    localparam int SEQUENCE_BASE_TICKS = 96;
    localparam int TICKS_PER_CODE = 28;

    localparam int BRIGHT_PLAN [PHASE_COUNT] = '{7, 0, 3, 7, 0, -1};
    localparam int ON_PLAN [PHASE_COUNT] = '{1, 0, 1, 0, 1, -1};
    localparam int IDLE_PLAN [PHASE_COUNT] = '{0, 65, 0, 12, 0, 65};
    localparam int STALL_PLAN [PHASE_COUNT] = '{0, 0, 65, 12, 0, 0};

    localparam logic [6:0] DIGIT_SEGMENTS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct {
        logic        kind;
        logic [13:0] number;
        logic [7:0]  dots;
        logic        zero_fill;
        logic [2:0]  shown_length;
        logic [1:0]  position;
        logic        dio_sense;
    } display_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [2:0]  cfg_data = 3'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [13:0] number = 14'd0;
    logic [7:0]  dots = 8'd0;
    logic        zero_fill = 1'b0;
    logic [2:0]  shown_length = 3'd0;
    logic [1:0]  position = 2'd0;
    logic        dio_sense = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        clk_release;
    logic        dio_release;
    logic        busy_res;
    logic        ack_missing;
    logic        request_dropped;
    logic        sequence_done;

    display_item_t pending_items[$];
    res_t          expected_lines[$];
    int            items_queued = 0;
    int            results_checked = 0;
    int            error_count = 0;
    int            quiet_cycles = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          in_taken = 1'b0;

    // Predicted state of the display writer.
    logic [7:0] digit_code [4];
    phase_t     line_phase = PH_START;
    logic [2:0] slot = 3'd0;
    logic [2:0] bit_idx = 3'd0;
    logic [7:0] shifter = 8'd0;
    logic       clk_line = 1'b1;
    logic       dio_line = 1'b1;
    logic       line_busy = 1'b0;
    logic [2:0] len_held = 3'd0;
    logic [1:0] pos_held = 2'd0;
    logic [2:0] bright_cfg = 3'd7;
    logic       disp_on_cfg = 1'b1;

    seven_segment_two_wire_display_writer uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .number(number),
        .dots(dots),
        .zero_fill(zero_fill),
        .shown_length(shown_length),
        .position(position),
        .dio_sense(dio_sense),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .clk_release(clk_release),
        .dio_release(dio_release),
        .busy_res(busy_res),
        .ack_missing(ack_missing),
        .request_dropped(request_dropped),
        .sequence_done(sequence_done)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] slot_code(input logic [2:0] s);
        case (s)
            SLOT_DATA_CMD: return CMD_DATA;
            SLOT_ADDR_CMD: return CMD_ADDR | 8'(pos_held);
            SLOT_DISP, SLOT_FINISHED: return CMD_DISP | {4'd0, disp_on_cfg, bright_cfg};
            default: return digit_code[(4 - int'(len_held) + int'(s) - 2) % 4];
        endcase
    endfunction

    function automatic res_t predict_lines(input display_item_t it);
        res_t        r;
        int unsigned remain;
        int unsigned d;
        logic        leading;
        logic        more;
        logic [2:0]  next_slot;
        logic [7:0]  code;
        r = '0;
        if (it.kind == KIND_REQUEST) begin
            if (line_busy) begin
                r.request_dropped = 1'b1;
            end else begin
                remain = (it.number > NUMBER_MAX) ? NUMBER_MAX : it.number;
                leading = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    d = remain / DIGIT_WEIGHT[k];
                    remain = remain - d * DIGIT_WEIGHT[k];
                    if (d != 0) begin
                        leading = 1'b0;
                    end
                    code = 8'd0;
                    if (d != 0 || it.zero_fill || !leading || k == 3) begin
                        code[6:0] = DIGIT_SEGMENTS[d];
                    end
                    code[7] = it.dots[7 - k];
                    digit_code[k] = code;
                end
                len_held = (it.shown_length > LENGTH_MAX) ? LENGTH_MAX : it.shown_length;
                pos_held = it.position;
                slot = SLOT_DATA_CMD;
                bit_idx = 3'd0;
                line_phase = PH_START;
                shifter = slot_code(SLOT_DATA_CMD);
                line_busy = 1'b1;
            end
        end else if (line_busy) begin
            case (line_phase)
                PH_START:
                begin
                    dio_line = 1'b0;
                    bit_idx = 3'd0;
                    line_phase = PH_BIT_LOW;
                end
                PH_BIT_LOW:
                begin
                    clk_line = 1'b0;
                    line_phase = PH_BIT_DATA;
                end
                PH_BIT_DATA:
                begin
                    dio_line = shifter[0];
                    line_phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH:
                begin
                    clk_line = 1'b1;
                    shifter = shifter >> 1;
                    if (bit_idx == 3'd7) begin
                        bit_idx = 3'd0;
                        line_phase = PH_ACK_LOW;
                    end else begin
                        bit_idx = bit_idx + 3'd1;
                        line_phase = PH_BIT_LOW;
                    end
                end
                PH_ACK_LOW:
                begin
                    clk_line = 1'b0;
                    dio_line = 1'b1;
                    line_phase = PH_ACK_HIGH;
                end
                PH_ACK_HIGH:
                begin
                    clk_line = 1'b1;
                    line_phase = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE:
                begin
                    r.ack_missing = it.dio_sense;
                    if (!it.dio_sense) begin
                        dio_line = 1'b0;
                    end
                    line_phase = PH_ACK_END;
                end
                PH_ACK_END:
                begin
                    clk_line = 1'b0;
                    more = 1'b0;
                    if (slot == SLOT_DATA_CMD) begin
                        next_slot = SLOT_ADDR_CMD;
                    end else if (slot == SLOT_ADDR_CMD) begin
                        if (len_held != 3'd0) begin
                            next_slot = SLOT_FIRST_CODE;
                            more = 1'b1;
                        end else begin
                            next_slot = SLOT_DISP;
                        end
                    end else if (slot < SLOT_DISP) begin
                        if (int'(slot) - 1 < int'(len_held)) begin
                            next_slot = slot + 3'd1;
                            more = 1'b1;
                        end else begin
                            next_slot = SLOT_DISP;
                        end
                    end else begin
                        next_slot = SLOT_FINISHED;
                    end
                    slot = next_slot;
                    if (more) begin
                        shifter = slot_code(next_slot);
                        line_phase = PH_BIT_LOW;
                    end else begin
                        line_phase = PH_STOP_LOW;
                    end
                end
                PH_STOP_LOW:
                begin
                    dio_line = 1'b0;
                    line_phase = PH_STOP_CLK;
                end
                PH_STOP_CLK:
                begin
                    clk_line = 1'b1;
                    line_phase = PH_STOP_DIO;
                end
                PH_STOP_DIO:
                begin
                    dio_line = 1'b1;
                    if (slot == SLOT_FINISHED) begin
                        line_busy = 1'b0;
                        r.sequence_done = 1'b1;
                        line_phase = PH_START;
                        slot = SLOT_DATA_CMD;
                    end else begin
                        shifter = slot_code(slot);
                        line_phase = PH_START;
                    end
                end
                default:
                begin
                    line_busy = 1'b0;
                    line_phase = PH_START;
                    slot = SLOT_DATA_CMD;
                    bit_idx = 3'd0;
                    clk_line = 1'b1;
                    dio_line = 1'b1;
                end
            endcase
        end
        r.clk_release = clk_line;
        r.dio_release = dio_line;
        r.busy_res = line_busy;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(negedge clk)
    begin : driver
        display_item_t nxt;
        if (rst_n) begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (!in_valid || in_taken) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    kind <= nxt.kind;
                    number <= nxt.number;
                    dots <= nxt.dots;
                    zero_fill <= nxt.zero_fill;
                    shown_length <= nxt.shown_length;
                    position <= nxt.position;
                    dio_sense <= nxt.dio_sense;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        display_item_t seen;
        res_t          want;
        res_t          got;
        if (rst_n) begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall) begin
                seen.kind = kind;
                seen.number = number;
                seen.dots = dots;
                seen.zero_fill = zero_fill;
                seen.shown_length = shown_length;
                seen.position = position;
                seen.dio_sense = dio_sense;
                expected_lines.push_back(predict_lines(seen));
            end
            if (out_valid && !out_stall) begin
                got = '{clk_release, dio_release, busy_res, ack_missing, request_dropped,
                        sequence_done};
                if (expected_lines.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %b", $time, got);
                    error_count++;
                end else begin
                    want = expected_lines.pop_front();
                    check_field("clk_release", want.clk_release, got.clk_release);
                    check_field("dio_release", want.dio_release, got.dio_release);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("ack_missing", want.ack_missing, got.ack_missing);
                    check_field("request_dropped", want.request_dropped, got.request_dropped);
                    check_field("sequence_done", want.sequence_done, got.sequence_done);
                    results_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic queue_item(input display_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_request(input int n, input int dot_bits, input logic lz,
                                input int len, input int pos);
        display_item_t it;
        it.kind = KIND_REQUEST;
        it.number = 14'(n);
        it.dots = 8'(dot_bits);
        it.zero_fill = lz;
        it.shown_length = 3'(len);
        it.position = 2'(pos);
        it.dio_sense = 1'($urandom_range(0, 1));
        queue_item(it);
    endtask

    task automatic push_random_request();
        int n;
        case ($urandom_range(0, 5))
            0: n = $urandom_range(0, 9);
            1: n = $urandom_range(0, 99);
            2: n = $urandom_range(0, 999);
            5: n = $urandom_range(10000, 16383);
            default: n = $urandom_range(0, 9999);
        endcase
        push_request(n, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 7),
                     $urandom_range(0, 3));
    endtask

    task automatic push_ticks(input int count, input int miss_pct, input int drop_pct);
        display_item_t it;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < drop_pct) begin
                push_random_request();
            end
            it.kind = KIND_TICK;
            it.number = 14'($urandom);
            it.dots = 8'($urandom);
            it.zero_fill = 1'($urandom);
            it.shown_length = 3'($urandom);
            it.position = 2'($urandom);
            it.dio_sense = ($urandom_range(0, 99) < miss_pct);
            queue_item(it);
        end
    endtask

    function automatic int ticks_for(input int len);
        return SEQUENCE_BASE_TICKS + TICKS_PER_CODE * ((len > 4) ? 4 : len);
    endfunction

    task automatic queue_display_run(inout int count);
        int style;
        int full;
        int ticks;
        style = $urandom_range(0, 99);
        if (style >= 92) begin
            push_ticks($urandom_range(1, 4), 50, 0);
        end
        push_random_request();
        full = ticks_for(int'(pending_items[pending_items.size() - 1].shown_length));
        ticks = (style >= 80 && style < 92) ? $urandom_range(1, full - 1) : full;
        push_ticks(ticks, 10, 2);
        count += ticks + 1;
    endtask

    task automatic wait_drained();
        while (results_checked != items_queued) begin
            @(negedge clk);
        end
    endtask

    // A sequence in progress keeps the line state busy; run it out before touching registers.
    task automatic settle_idle();
        wait_drained();
        while (line_busy) begin
            push_ticks(1, 0, 0);
            wait_drained();
        end
    endtask

    task automatic write_register(input logic idx, input int value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 3'(value);
        if (idx == CFG_BRIGHTNESS) begin
            bright_cfg = 3'(value);
        end else begin
            disp_on_cfg = 1'(value);
        end
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int phase_items;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle_idle();
            send_idle_pct = 0;
            recv_stall_pct = 0;
            write_register(CFG_BRIGHTNESS,
                           (BRIGHT_PLAN[p] < 0) ? $urandom_range(1, 6) : BRIGHT_PLAN[p]);
            write_register(CFG_DISPLAY_ON,
                           (ON_PLAN[p] < 0) ? $urandom_range(0, 1) : ON_PLAN[p]);
            send_idle_pct = IDLE_PLAN[p];
            recv_stall_pct = STALL_PLAN[p];
            if (p == 0) begin
                push_ticks(1, 100, 0);
                push_request(0, 8'h00, 1'b0, 4, 0);
                push_ticks(1, 0, 0);
                push_request(9999, 8'hFF, 1'b1, 7, 3);
                push_ticks(ticks_for(4) - 1, 0, 0);
                push_request(16383, 8'hFF, 1'b1, 7, 3);
                push_ticks(ticks_for(7), 0, 0);
                push_request(7, 8'h0F, 1'b1, 2, 2);
                push_ticks(ticks_for(2), 0, 0);
                push_request(10, 8'hA0, 1'b0, 0, 3);
                push_ticks(ticks_for(0), 0, 0);
                push_request(305, 8'h50, 1'b0, 1, 1);
                push_ticks(ticks_for(1), 100, 0);
                push_ticks(1, 0, 0);
            end else begin
                phase_items = 0;
                while (phase_items < RANDOM_ITEMS_PER_PHASE) begin
                    queue_display_run(phase_items);
                end
            end
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== seven_segment_two_wire_display_writer.f =====
+incdir+sv
sv/ssdw_pkg.sv
sv/seven_segment_two_wire_display_writer.sv
sv/ssdw_checker.sv
tb/tb_seven_segment_two_wire_display_writer.sv
